// ----- rtl/core/ecs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecs_pkg: event counter semaphore shared definitions
// Field widths, command and status codes, register indexes and the packed
// access and result records used by the core and the top level.
// ----------------------------------------------------------------------------
package ecs_pkg;

    localparam int COUNT_W    = 64;
    localparam int BYTES_W    = 16;
    localparam int WAKE_W     = 16;
    localparam int CFG_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CMD_W      = 2;
    localparam int IN_DATA_W  = 88;
    localparam int OUT_DATA_W = 88;

    localparam logic [COUNT_W-1:0] ALL_ONES    = '1;
    localparam logic [COUNT_W-1:0] WRITE_LIMIT = 64'hffff_ffff_ffff_fffe;
    localparam logic [COUNT_W-1:0] WAKE_MAX    = 64'h0000_0000_0000_ffff;
    localparam logic [BYTES_W-1:0] MIN_BYTES   = 16'd8;

    localparam logic [CFG_IDX_W-1:0] CFG_SEMAPHORE_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NONBLOCKING    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_COUNT  = 2'd2;

    typedef enum logic [CMD_W-1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_POLL  = 2'd2
    } ecs_cmd_t;

    typedef enum logic [1:0] {
        ST_DONE        = 2'd0,
        ST_INVALID     = 2'd1,
        ST_WOULD_BLOCK = 2'd2,
        ST_WAITING     = 2'd3
    } ecs_status_t;

    // low bits last
    typedef struct packed {
        logic                want_write;
        logic                want_read;
        logic [COUNT_W-1:0]  write_value;
        logic [BYTES_W-1:0]  buffer_bytes;
        ecs_cmd_t            cmd;
    } ecs_item_t;

    typedef struct packed {
        logic                waiter_overflow;
        logic                poll_writable;
        logic                poll_readable;
        logic                wake_readers;
        logic [WAKE_W-1:0]   wake_count;
        logic [COUNT_W-1:0]  read_value;
        ecs_status_t         status;
    } ecs_result_t;

    localparam int RESULT_W = $bits(ecs_result_t);

endpackage

// ----- rtl/core/ecs_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecs_core: event counter semaphore update logic
// Works out the result of one access and the next counter and waiter counts
// from the current state and mode bits.
// ----------------------------------------------------------------------------
module ecs_core
    import ecs_pkg::*;
#(
    parameter int WAITER_BITS = 16
) (
    input  ecs_item_t              item,
    input  logic                   semaphore_mode,
    input  logic                   nonblocking,
    input  logic [COUNT_W-1:0]     count,
    input  logic [WAITER_BITS-1:0] readers,
    input  logic [WAITER_BITS-1:0] writers,
    output ecs_result_t            result,
    output logic [COUNT_W-1:0]     count_next,
    output logic [WAITER_BITS-1:0] readers_next,
    output logic [WAITER_BITS-1:0] writers_next
);

    logic [COUNT_W-1:0] sum;
    logic [COUNT_W-1:0] readers_wide;
    logic [COUNT_W-1:0] writers_wide;

    function automatic logic [COUNT_W-1:0] min3(input logic [COUNT_W-1:0] a,
                                                input logic [COUNT_W-1:0] b,
                                                input logic [COUNT_W-1:0] c);
        logic [COUNT_W-1:0] m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    assign sum          = count + item.write_value;
    assign readers_wide = COUNT_W'(readers);
    assign writers_wide = COUNT_W'(writers);

    always_comb begin
        logic [COUNT_W-1:0] wake;
        wake         = '0;
        result       = '0;
        count_next   = count;
        readers_next = readers;
        writers_next = writers;
        case (item.cmd)
            CMD_READ: begin
                if (item.buffer_bytes < MIN_BYTES) begin
                    result.status = ST_INVALID;
                end else if (count != '0) begin
                    if (semaphore_mode) begin
                        result.read_value = COUNT_W'(1);
                        count_next        = count - COUNT_W'(1);
                        wake              = COUNT_W'(writers != '0);
                    end else begin
                        result.read_value = count;
                        count_next        = '0;
                        wake              = min3(writers_wide, count, WAKE_MAX);
                    end
                    writers_next = writers - wake[WAITER_BITS-1:0];
                end else if (nonblocking) begin
                    result.status = ST_WOULD_BLOCK;
                end else begin
                    result.status = ST_WAITING;
                    if (&readers) begin
                        result.waiter_overflow = 1'b1;
                    end else begin
                        readers_next = readers + WAITER_BITS'(1);
                    end
                end
            end
            CMD_WRITE: begin
                if (item.buffer_bytes < MIN_BYTES || item.write_value == ALL_ONES) begin
                    result.status = ST_INVALID;
                end else if (item.write_value < ~count) begin
                    count_next          = sum;
                    result.wake_readers = 1'b1;
                    if (semaphore_mode) begin
                        wake = min3(readers_wide, sum, WAKE_MAX);
                    end else begin
                        wake = COUNT_W'(readers != '0);
                    end
                    readers_next = readers - wake[WAITER_BITS-1:0];
                end else if (nonblocking) begin
                    result.status = ST_WOULD_BLOCK;
                end else begin
                    result.status = ST_WAITING;
                    if (&writers) begin
                        result.waiter_overflow = 1'b1;
                    end else begin
                        writers_next = writers + WAITER_BITS'(1);
                    end
                end
            end
            CMD_POLL: begin
                result.poll_readable = item.want_read && (count != '0);
                result.poll_writable = item.want_write && (count < WRITE_LIMIT);
            end
            default: begin
                result.status = ST_INVALID;
            end
        endcase
        result.wake_count = wake[WAKE_W-1:0];
    end

endmodule

// ----- rtl/core/event_counter_semaphore_unit.sv -----
`timescale 1ns / 1ps
// path: an input transfer is held in the input register, then the result register
//   (which also updates counter and waiter counts) drives the output
// throughput: one access per cycle while the output is not stalled; the counter is updated with the result register
// reset: synchronous, clears counter, waiter counts, mode bits and both
//   valid flags
// ----------------------------------------------------------------------------
// event_counter_semaphore_unit: event counter with reader and writer waiters
// Takes read, write and poll accesses on a stream input and returns one
// result per access on a stream output.
// ----------------------------------------------------------------------------
module event_counter_semaphore_unit
    import ecs_pkg::*;
#(
    parameter int WAITER_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_wdata,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    // buffer_bytes, write_value, poll_want_read, poll_want_write, zero pad
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // cmd
    input  logic [CMD_W-1:0]      s_tuser,

    output logic                  m_tvalid,
    input  logic                  m_tready,
    // status, read_value, wake_count, wake_readers, poll_readable,
    // poll_writable, waiter_overflow, zero pad
    output logic [OUT_DATA_W-1:0] m_tdata
);

    logic                   in_valid_reg;
    ecs_item_t              item_reg;
    logic                   out_valid_reg;
    ecs_result_t            result_reg;
    logic [COUNT_W-1:0]     count_reg;
    logic [WAITER_BITS-1:0] readers_reg;
    logic [WAITER_BITS-1:0] writers_reg;
    logic                   semaphore_mode_reg;
    logic                   nonblocking_reg;

    ecs_item_t              item_in;
    ecs_result_t            result_next;
    logic [COUNT_W-1:0]     count_next;
    logic [WAITER_BITS-1:0] readers_next;
    logic [WAITER_BITS-1:0] writers_next;
    logic                   advance;
    logic                   fire;
    logic                   in_transfer;

    assign advance     = !out_valid_reg || m_tready;
    assign s_tready    = !in_valid_reg || advance;
    assign in_transfer = s_tvalid && s_tready;
    assign fire        = in_valid_reg && advance;

    always_comb begin
        item_in              = '0;
        item_in.cmd          = ecs_cmd_t'(s_tuser);
        item_in.buffer_bytes = s_tdata[BYTES_W-1:0];
        item_in.write_value  = s_tdata[BYTES_W +: COUNT_W];
        item_in.want_read    = s_tdata[BYTES_W + COUNT_W];
        item_in.want_write   = s_tdata[BYTES_W + COUNT_W + 1];
    end

    ecs_core #(
        .WAITER_BITS (WAITER_BITS)
    ) u_core (
        .item           (item_reg),
        .semaphore_mode (semaphore_mode_reg),
        .nonblocking    (nonblocking_reg),
        .count          (count_reg),
        .readers        (readers_reg),
        .writers        (writers_reg),
        .result         (result_next),
        .count_next     (count_next),
        .readers_next   (readers_next),
        .writers_next   (writers_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            count_reg          <= '0;
            readers_reg        <= '0;
            writers_reg        <= '0;
            semaphore_mode_reg <= 1'b0;
            nonblocking_reg    <= 1'b0;
        end else begin
            if (in_transfer) begin
                in_valid_reg <= 1'b1;
            end else if (fire) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_SEMAPHORE_MODE: begin
                        semaphore_mode_reg <= cfg_wdata[0];
                    end
                    CFG_NONBLOCKING: begin
                        nonblocking_reg <= cfg_wdata[0];
                    end
                    CFG_INITIAL_COUNT: begin
                        count_reg   <= COUNT_W'(cfg_wdata);
                        readers_reg <= '0;
                        writers_reg <= '0;
                    end
                    default: begin
                    end
                endcase
            end else if (fire) begin
                count_reg   <= count_next;
                readers_reg <= readers_next;
                writers_reg <= writers_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_transfer) begin
            item_reg <= item_in;
        end
        if (fire) begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W - RESULT_W){1'b0}}, result_reg};

endmodule

// ----- rtl/core/ecs_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecs_checker: port-level checks for the event counter semaphore unit
// Watches the handshakes and reset behaviour seen on the top-level ports.
// ----------------------------------------------------------------------------
module ecs_checker
    import ecs_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // free output never blocks input
    a_ready_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input stalled while output ready");

    // every new result comes from an earlier input transfer
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("result without input transfer");

    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("valid or stall after reset");

endmodule

bind event_counter_semaphore_unit ecs_checker u_ecs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- verif/event_counter_semaphore_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// event_counter_semaphore_unit_tb: self-checking bench for the event counter
// A queue-fed driver sends read, write, poll and unknown accesses under
// several register settings and random stalls on both sides. An in-bench
// copy of the counter and waiter state predicts each result, and the
// monitor checks every returned transfer field by field, in order.
// ----------------------------------------------------------------------------
module event_counter_semaphore_unit_tb;
    import ecs_pkg::*;

    localparam int                 WAITERS_W  = 16;
    localparam logic [WAITERS_W-1:0] WAITERS_MAX = '1;
    localparam logic [CMD_W-1:0]   CMD_UNKNOWN = 2'd3;
    localparam int                 STALL_LIMIT = 2000;
    localparam int                 ERR_SHOWN   = 100;

    typedef struct {
        logic [CMD_W-1:0]   cmd;
        logic [BYTES_W-1:0] bytes;
        logic [COUNT_W-1:0] wval;
        logic               want_rd;
        logic               want_wr;
    } access_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_W-1:0]      cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic [CMD_W-1:0]      s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    // predictor state
    logic                 sem_mode   = 1'b0;
    logic                 nonblk     = 1'b0;
    logic [COUNT_W-1:0]   evt_count  = '0;
    logic [WAITERS_W-1:0] rd_waiters = '0;
    logic [WAITERS_W-1:0] wr_waiters = '0;

    access_t     pending_accesses[$];
    ecs_result_t expected_results[$];
    access_t     cur_access;
    int          src_idle_pct = 0;
    int          snk_idle_pct = 0;
    int          n_fail       = 0;
    int          idle_cycles  = 0;

    event_counter_semaphore_unit #(
        .WAITER_BITS (WAITERS_W)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic logic [COUNT_W-1:0] wake_limit(logic [COUNT_W-1:0] waiters,
                                                      logic [COUNT_W-1:0] bound);
        logic [COUNT_W-1:0] m;
        m = (waiters < bound) ? waiters : bound;
        return (m < WAKE_MAX) ? m : WAKE_MAX;
    endfunction

    function automatic ecs_result_t predict_access(access_t a);
        ecs_result_t        r;
        logic [COUNT_W-1:0] wake;
        logic               blocked;
        logic               on_readers;
        r          = '0;
        r.status   = ST_DONE;
        wake       = '0;
        blocked    = 1'b0;
        on_readers = 1'b0;
        case (a.cmd)
            CMD_READ: begin
                if (a.bytes < MIN_BYTES) begin
                    r.status = ST_INVALID;
                end else if (evt_count != '0) begin
                    if (sem_mode) begin
                        r.read_value = 64'd1;
                        evt_count    = evt_count - 64'd1;
                        wake         = wake_limit(COUNT_W'(wr_waiters), 64'd1);
                    end else begin
                        r.read_value = evt_count;
                        evt_count    = '0;
                        wake         = wake_limit(COUNT_W'(wr_waiters), r.read_value);
                    end
                    wr_waiters = wr_waiters - wake[WAITERS_W-1:0];
                end else begin
                    blocked    = 1'b1;
                    on_readers = 1'b1;
                end
            end
            CMD_WRITE: begin
                if (a.bytes < MIN_BYTES || a.wval == ALL_ONES) begin
                    r.status = ST_INVALID;
                end else if (a.wval < (ALL_ONES - evt_count)) begin
                    evt_count      = evt_count + a.wval;
                    r.wake_readers = 1'b1;
                    if (sem_mode)
                        wake = wake_limit(COUNT_W'(rd_waiters), evt_count);
                    else
                        wake = wake_limit(COUNT_W'(rd_waiters), 64'd1);
                    rd_waiters = rd_waiters - wake[WAITERS_W-1:0];
                end else begin
                    blocked = 1'b1;
                end
            end
            CMD_POLL: begin
                r.poll_readable = a.want_rd && (evt_count != '0);
                r.poll_writable = a.want_wr && (evt_count < WRITE_LIMIT);
            end
            default: begin
                r.status = ST_INVALID;
            end
        endcase
        if (blocked) begin
            if (nonblk) begin
                r.status = ST_WOULD_BLOCK;
            end else begin
                r.status = ST_WAITING;
                if (on_readers) begin
                    if (rd_waiters == WAITERS_MAX) r.waiter_overflow = 1'b1;
                    else rd_waiters = rd_waiters + WAITERS_W'(1);
                end else begin
                    if (wr_waiters == WAITERS_MAX) r.waiter_overflow = 1'b1;
                    else wr_waiters = wr_waiters + WAITERS_W'(1);
                end
            end
        end
        r.wake_count = wake[WAKE_W-1:0];
        return r;
    endfunction

    // driver, prediction taken at the input transfer
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                expected_results.push_back(predict_access(cur_access));
            if (!s_tvalid || s_tready) begin
                if (pending_accesses.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    cur_access = pending_accesses.pop_front();
                    s_tdata  <= {6'b0, cur_access.want_wr, cur_access.want_rd,
                                 cur_access.wval, cur_access.bytes};
                    s_tuser  <= cur_access.cmd;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= snk_idle_pct);
    end

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            if (n_fail < ERR_SHOWN)
                $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
            n_fail++;
        end
    endtask

    // monitor
    always @(posedge aclk) begin
        ecs_result_t got;
        ecs_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = ecs_result_t'(m_tdata[RESULT_W-1:0]);
            if (expected_results.size() == 0) begin
                if (n_fail < ERR_SHOWN)
                    $error("result transfer with no access outstanding");
                n_fail++;
            end else begin
                want = expected_results.pop_front();
                check_field("status", 64'(want.status), 64'(got.status));
                check_field("read_value", want.read_value, got.read_value);
                check_field("wake_count", 64'(want.wake_count), 64'(got.wake_count));
                check_field("wake_readers", 64'(want.wake_readers),
                            64'(got.wake_readers));
                check_field("poll_readable", 64'(want.poll_readable),
                            64'(got.poll_readable));
                check_field("poll_writable", 64'(want.poll_writable),
                            64'(got.poll_writable));
                check_field("waiter_overflow", 64'(want.waiter_overflow),
                            64'(got.waiter_overflow));
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= STALL_LIMIT) begin
                $display("status: fail");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    task automatic push_access(input logic [CMD_W-1:0] cmd, input logic [BYTES_W-1:0] bytes,
                               input logic [COUNT_W-1:0] wval, input logic want_rd,
                               input logic want_wr);
        access_t a;
        a.cmd     = cmd;
        a.bytes   = bytes;
        a.wval    = wval;
        a.want_rd = want_rd;
        a.want_wr = want_wr;
        pending_accesses.push_back(a);
    endtask

    // sampled away from the rising edge so the driver has settled
    task automatic wait_drained();
        while (pending_accesses.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(negedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // mode bits carry random upper bits, only bit 0 counts
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_SEMAPHORE_MODE: sem_mode = val[0];
            CFG_NONBLOCKING:    nonblk   = val[0];
            CFG_INITIAL_COUNT: begin
                evt_count  = {32'h0, val};
                rd_waiters = '0;
                wr_waiters = '0;
            end
            default: ;
        endcase
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [COUNT_W-1:0] rand_wval();
        int r;
        r = $urandom_range(99);
        if (r < 25)      return 64'($urandom_range(3));
        else if (r < 45) return {32'h0, $urandom};
        else if (r < 70) return {$urandom, $urandom};
        else if (r < 82) return WRITE_LIMIT - 64'($urandom_range(3));
        else if (r < 88) return ALL_ONES;
        else             return {$urandom | 32'h8000_0000, $urandom};
    endfunction

    function automatic logic [BYTES_W-1:0] rand_bytes();
        int r;
        r = $urandom_range(99);
        if (r < 10)      return BYTES_W'($urandom_range(7));
        else if (r < 15) return MIN_BYTES;
        else if (r < 20) return '1;
        else             return BYTES_W'($urandom_range(65535, 8));
    endfunction

    task automatic push_random();
        int                 r;
        logic [CMD_W-1:0]   cmd;
        r = $urandom_range(99);
        if (r < 38)      cmd = CMD_READ;
        else if (r < 76) cmd = CMD_WRITE;
        else if (r < 96) cmd = CMD_POLL;
        else             cmd = CMD_UNKNOWN;
        push_access(cmd, rand_bytes(), rand_wval(), 1'($urandom_range(1)),
                    1'($urandom_range(1)));
    endtask

    task automatic random_setting();
        int          r;
        logic [31:0] init_v;
        r = $urandom_range(3);
        if (r == 0)      init_v = 32'h0;
        else if (r == 1) init_v = 32'hffff_ffff;
        else if (r == 2) init_v = 32'($urandom_range(5));
        else             init_v = $urandom;
        write_reg(CFG_SEMAPHORE_MODE,
                  {31'($urandom_range(32'h7fff_ffff)), 1'($urandom_range(1))});
        write_reg(CFG_NONBLOCKING,
                  {31'($urandom_range(32'h7fff_ffff)), 1'($urandom_range(3) == 0)});
        write_reg(CFG_INITIAL_COUNT, init_v);
    endtask

    initial begin
        int mode;
        int ph;
        int i;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        src_idle_pct = 28;
        snk_idle_pct = 62;

        // directed: reset settings, drain mode, blocking
        push_access(CMD_POLL, '0, '0, 1'b1, 1'b1);
        push_access(CMD_READ, 16'd7, '0, 1'b0, 1'b0);
        push_access(CMD_WRITE, '0, 64'd3, 1'b0, 1'b0);
        push_access(CMD_UNKNOWN, '1, '1, 1'b1, 1'b1);
        push_access(CMD_WRITE, MIN_BYTES, ALL_ONES, 1'b0, 1'b0);
        push_access(CMD_READ, MIN_BYTES, '0, 1'b0, 1'b0);
        push_access(CMD_WRITE, '1, 64'd5, 1'b0, 1'b0);
        push_access(CMD_READ, '1, '0, 1'b0, 1'b0);
        push_access(CMD_WRITE, MIN_BYTES, WRITE_LIMIT, 1'b0, 1'b0);
        push_access(CMD_POLL, 16'd3, '0, 1'b1, 1'b1);
        push_access(CMD_WRITE, MIN_BYTES, 64'd1, 1'b0, 1'b0);
        push_access(CMD_WRITE, MIN_BYTES, 64'd0, 1'b0, 1'b0);
        push_access(CMD_READ, MIN_BYTES, '0, 1'b0, 1'b0);
        push_access(CMD_POLL, MIN_BYTES, '1, 1'b0, 1'b0);
        push_access(CMD_POLL, MIN_BYTES, '0, 1'b1, 1'b0);
        wait_drained();

        // directed: semaphore mode, would-block reporting
        write_reg(CFG_SEMAPHORE_MODE, 32'h1);
        write_reg(CFG_NONBLOCKING, 32'hffff_ffff);
        write_reg(CFG_INITIAL_COUNT, 32'hffff_ffff);
        push_access(CMD_READ, MIN_BYTES, '0, 1'b0, 1'b0);
        push_access(CMD_READ, '1, '0, 1'b0, 1'b0);
        push_access(CMD_WRITE, MIN_BYTES, 64'hffff_ffff_0000_0000, 1'b0, 1'b0);
        push_access(CMD_WRITE, MIN_BYTES, WRITE_LIMIT, 1'b0, 1'b0);
        push_access(CMD_POLL, MIN_BYTES, '0, 1'b1, 1'b1);
        wait_drained();
        write_reg(CFG_INITIAL_COUNT, 32'h0);
        push_access(CMD_READ, MIN_BYTES, '0, 1'b0, 1'b0);
        push_access(CMD_POLL, MIN_BYTES, '0, 1'b1, 1'b1);
        wait_drained();

        for (mode = 0; mode < 3; mode++) begin
            src_idle_pct = (mode == 0) ? 28 : (mode == 1) ? 62 : 0;
            snk_idle_pct = (mode == 0) ? 62 : (mode == 1) ? 28 : 0;
            for (ph = 0; ph < 4; ph++) begin
                random_setting();
                for (i = 0; i < 155; i++)
                    push_random();
                wait_drained();
            end
        end

        repeat (8) @(posedge aclk);
        if (expected_results.size() != 0) begin
            $error("%0d results never returned", expected_results.size());
            n_fail++;
        end
        if (n_fail == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
